// ===== rtl/cla_pkg.sv =====
// ----------------------------------------------------------------------------
// cla_pkg
// Shared constants, codes and controller/datapath interface types for the
// command line assembler with echo.
// ----------------------------------------------------------------------------
package cla_pkg;

    // default line buffer size in bytes
    localparam int LINE_BYTES_DEF = 32;

    // result kinds
    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_CMD   = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    // command status
    localparam logic [1:0] ST_CLEAR     = 2'd0;
    localparam logic [1:0] ST_RECEIVING = 2'd1;
    localparam logic [1:0] ST_RECEIVED  = 2'd2;

    // request types
    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h00;

    // actions applied by the datapath when a word is accepted
    localparam logic [2:0] ACT_IDLE  = 3'd0;
    localparam logic [2:0] ACT_BS    = 3'd1;
    localparam logic [2:0] ACT_EOL   = 3'd2;
    localparam logic [2:0] ACT_CHAR  = 3'd3;
    localparam logic [2:0] ACT_NOCMD = 3'd4;
    localparam logic [2:0] ACT_EMPTY = 3'd5;
    localparam logic [2:0] ACT_FETCH = 3'd6;

    // output data sources
    localparam logic [1:0] SRC_CONST = 2'd0;
    localparam logic [1:0] SRC_CHAR  = 2'd1;
    localparam logic [1:0] SRC_MEM   = 2'd2;

    // datapath status toward the controller
    typedef struct packed {
        logic fetch;
        logic high;
        logic bs;
        logic eol;
        logic line_empty;
        logic line_full;
        logic cmd_ready;
        logic cmd_empty;
        logic out_free;
        logic rd_last;
    } dp_stat_t;

    // controller commands toward the datapath
    typedef struct packed {
        logic [2:0] act;
        logic       emit;
        logic [1:0] kind;
        logic [1:0] src;
        logic [7:0] cbyte;
        logic       last;
        logic       rd_next;
    } ctl_cmd_t;

endpackage

// ===== rtl/cla_datapath.sv =====
// ----------------------------------------------------------------------------
// cla_datapath
// Line and command buffers (one banked memory), counters, status and the
// output register.
// ----------------------------------------------------------------------------
module cla_datapath
    import cla_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_type,
    input  logic [7:0] rx_byte,
    input  ctl_cmd_t   cmd,
    input  logic       out_stall,
    output dp_stat_t   stat,
    output logic       out_valid,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic       last,
    output logic [1:0] status
);

    localparam int CNT_W     = $clog2(LINE_BYTES);
    localparam int ADDR_W    = CNT_W + 1;
    localparam int MEM_DEPTH = 2 * (1 << CNT_W);

    // two banks: one holds the latched command, the other the line in edit
    logic [7:0]        mem [MEM_DEPTH];

    logic [CNT_W-1:0]  line_count_reg, line_count_next;
    logic [CNT_W-1:0]  cmd_count_reg, cmd_count_next;
    logic              bank_reg, bank_next;
    logic [1:0]        status_reg, status_next;
    logic [7:0]        char_reg;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [7:0]        rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  ptr_inc;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg;
    logic [7:0]        data_reg;
    logic              last_reg;
    logic [1:0]        status_out_reg;
    logic [7:0]        emit_data;

    // status toward the controller
    assign ptr_inc             = ptr_reg + CNT_W'(1);
    assign stat.fetch          = (req_type == REQ_FETCH);
    assign stat.high           = rx_byte[7];
    assign stat.bs             = (rx_byte == CH_BS);
    assign stat.eol            = (rx_byte == CH_LF) || (rx_byte == CH_CR);
    assign stat.line_empty     = (line_count_reg == '0);
    assign stat.line_full      = (line_count_reg >= CNT_W'(LINE_BYTES - 2));
    assign stat.cmd_ready      = (status_reg == ST_RECEIVED);
    assign stat.cmd_empty      = (cmd_count_reg == '0);
    assign stat.out_free       = !out_valid_reg || !out_stall;
    assign stat.rd_last        = (ptr_inc == cmd_count_reg);

    // counters, bank and status update per action
    always_comb
    begin
        line_count_next = line_count_reg;
        cmd_count_next  = cmd_count_reg;
        bank_next       = bank_reg;
        status_next     = status_reg;
        unique case (cmd.act)
            ACT_BS:
            begin
                line_count_next = line_count_reg - CNT_W'(1);
            end
            ACT_EOL:
            begin
                bank_next       = !bank_reg;
                cmd_count_next  = line_count_reg;
                line_count_next = '0;
                status_next     = ST_RECEIVED;
            end
            ACT_CHAR:
            begin
                line_count_next = line_count_reg + CNT_W'(1);
                status_next     = ST_RECEIVING;
            end
            ACT_EMPTY, ACT_FETCH:
            begin
                status_next = ST_CLEAR;
            end
            default:
            begin
            end
        endcase
    end

    // read pointer for command streaming
    always_comb
    begin
        rd_en    = 1'b0;
        ptr_next = ptr_reg;
        if (cmd.act == ACT_FETCH)
        begin
            rd_en    = 1'b1;
            ptr_next = '0;
        end
        else if (cmd.rd_next)
        begin
            rd_en    = 1'b1;
            ptr_next = ptr_inc;
        end
    end

    assign rd_addr = {bank_reg, ptr_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
            cmd_count_reg  <= '0;
            bank_reg       <= 1'b0;
            status_reg     <= ST_CLEAR;
            ptr_reg        <= '0;
        end
        else
        begin
            line_count_reg <= line_count_next;
            cmd_count_reg  <= cmd_count_next;
            bank_reg       <= bank_next;
            status_reg     <= status_next;
            ptr_reg        <= ptr_next;
        end
    end

    // line memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.act == ACT_CHAR)
        begin
            mem[{!bank_reg, line_count_reg}] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // echoed character
    always_ff @(posedge clk)
    begin
        if (cmd.act == ACT_CHAR)
        begin
            char_reg <= rx_byte;
        end
    end

    // output data select
    always_comb
    begin
        unique case (cmd.src)
            SRC_CHAR: emit_data = char_reg;
            SRC_MEM:  emit_data = rd_data_reg;
            default:  emit_data = cmd.cbyte;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg       <= cmd.kind;
            data_reg       <= emit_data;
            last_reg       <= cmd.last;
            status_out_reg <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign last      = last_reg;
    assign status    = status_out_reg;

endmodule

// ===== rtl/cla_ctrl.sv =====
// ----------------------------------------------------------------------------
// cla_ctrl
// Controller: decodes each accepted word and sequences the echo and
// command result words.
// ----------------------------------------------------------------------------
module cla_ctrl
    import cla_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  dp_stat_t stat,
    output logic     in_stall,
    output ctl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ECHO  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;

    localparam logic [2:0] SEQ_BS    = 3'd0;
    localparam logic [2:0] SEQ_EOL   = 3'd1;
    localparam logic [2:0] SEQ_CHAR  = 3'd2;
    localparam logic [2:0] SEQ_NONE  = 3'd3;
    localparam logic [2:0] SEQ_EMPTY = 3'd4;

    logic [1:0] state_reg, state_next;
    logic [2:0] seq_reg, seq_next;
    logic [1:0] step_reg, step_next;
    logic       fin;

    assign in_stall = !fin;

    always_comb
    begin
        cmd        = '0;
        cmd.act    = ACT_IDLE;
        fin        = 1'b0;
        state_next = state_reg;
        seq_next   = seq_reg;
        step_next  = step_reg;

        // emit the current result word
        unique case (state_reg)
            S_IDLE:
            begin
                fin = 1'b1;
            end
            S_ECHO:
            begin
                cmd.kind  = KIND_ECHO;
                cmd.src   = SRC_CONST;
                cmd.cbyte = CH_ZERO;
                unique case (seq_reg)
                    SEQ_BS:
                    begin
                        cmd.cbyte = (step_reg == 2'd1) ? CH_SPACE : CH_BS;
                        cmd.last  = (step_reg == 2'd2);
                    end
                    SEQ_EOL:
                    begin
                        cmd.cbyte = (step_reg == 2'd0) ? CH_CR : CH_LF;
                        cmd.last  = (step_reg == 2'd1);
                    end
                    SEQ_CHAR:
                    begin
                        cmd.src  = SRC_CHAR;
                        cmd.last = 1'b1;
                    end
                    SEQ_NONE:
                    begin
                        cmd.kind = KIND_NONE;
                        cmd.last = 1'b1;
                    end
                    default:
                    begin
                        cmd.kind = KIND_EMPTY;
                        cmd.last = 1'b1;
                    end
                endcase
                if (stat.out_free)
                begin
                    cmd.emit  = 1'b1;
                    fin       = cmd.last;
                    step_next = step_reg + 2'd1;
                end
            end
            S_FETCH:
            begin
                cmd.kind = KIND_CMD;
                cmd.src  = SRC_MEM;
                cmd.last = stat.rd_last;
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.rd_next = !stat.rd_last;
                    fin         = stat.rd_last;
                end
            end
            default:
            begin
                fin = 1'b1;
            end
        endcase

        // decode the next word once the current one is done
        if (fin)
        begin
            state_next = S_IDLE;
            step_next  = 2'd0;
            if (in_valid)
            begin
                priority if (stat.fetch)
                begin
                    priority if (!stat.cmd_ready)
                    begin
                        cmd.act    = ACT_NOCMD;
                        seq_next   = SEQ_NONE;
                        state_next = S_ECHO;
                    end
                    else if (stat.cmd_empty)
                    begin
                        cmd.act    = ACT_EMPTY;
                        seq_next   = SEQ_EMPTY;
                        state_next = S_ECHO;
                    end
                    else
                    begin
                        cmd.act    = ACT_FETCH;
                        state_next = S_FETCH;
                    end
                end
                else if (stat.high)
                begin
                    cmd.act = ACT_IDLE;
                end
                else if (stat.bs)
                begin
                    if (!stat.line_empty)
                    begin
                        cmd.act    = ACT_BS;
                        seq_next   = SEQ_BS;
                        state_next = S_ECHO;
                    end
                end
                else if (stat.eol || stat.line_full)
                begin
                    cmd.act    = ACT_EOL;
                    seq_next   = SEQ_EOL;
                    state_next = S_ECHO;
                end
                else
                begin
                    cmd.act    = ACT_CHAR;
                    seq_next   = SEQ_CHAR;
                    state_next = S_ECHO;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seq_reg   <= SEQ_NONE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== rtl/command_line_assembler_with_echo.sv =====
// ----------------------------------------------------------------------------
// command_line_assembler_with_echo
// Collects typed bytes into a command line, echoes them, and hands the
// latched command to the host on a fetch request.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): req_type selects a received byte
// (rx_byte) or a fetch of the completed command. Output channel
// (out_valid/out_stall) carries result words: kind, data, last, status.
// A word is taken at an edge where valid is high and stall is low.
// Accepting a word registers the controller state; the first result is then
// loaded into the output register once it is free. Results follow one per
// cycle while the receiver does not stall: a plain character gives one, a
// backspace three, end of line two, a fetch one per command byte (the memory
// read is pipelined one ahead). The next input word is taken in the cycle its
// predecessor's final result is loaded, so single-echo bytes sustain one word
// per cycle unstalled; a byte with no result leaves the controller idle.
// Line and command share one banked memory; end of line swaps the banks.
// Reset clears counts, status and control; memory contents need none.
// While the receiver stalls, the output word holds, result sequencing
// pauses and in_stall stays high until the final result is loaded.
// ----------------------------------------------------------------------------
module command_line_assembler_with_echo
    import cla_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic       last,
    output logic [1:0] status
);

    dp_stat_t stat;
    ctl_cmd_t cmd;

    // controller
    cla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // datapath
    cla_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_type  (req_type),
        .rx_byte   (rx_byte),
        .cmd       (cmd),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .kind      (kind),
        .data      (data),
        .last      (last),
        .status    (status)
    );

endmodule

// ===== rtl/cla_checker.sv =====
// ----------------------------------------------------------------------------
// cla_checker
// Port-level checks for the command line assembler, bound to the top level.
// ----------------------------------------------------------------------------
module cla_checker
    import cla_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] data,
    input logic       last,
    input logic [1:0] status
);

    // stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data)
            && $stable(last) && $stable(status))
        else $error("stalled output word changed");

    // no-command and empty-command replies are single words with zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_NONE || kind == KIND_EMPTY) |-> last && data == CH_ZERO)
        else $error("status reply not a single zero word");

    // a fetched command leaves the status clear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_CMD || kind == KIND_EMPTY) |-> status == ST_CLEAR)
        else $error("status not cleared by fetch");

    // no-command reply never while a command waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_NONE |-> status != ST_RECEIVED)
        else $error("no-command reply while command received");

    // status code on an echo word is never the unused value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ECHO |-> status == ST_RECEIVING || status == ST_RECEIVED
            || status == ST_CLEAR)
        else $error("bad status on echo word");

endmodule

bind command_line_assembler_with_echo cla_checker u_cla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data      (data),
    .last      (last),
    .status    (status)
);

// ===== sim/command_line_assembler_with_echo_test.sv =====
// ----------------------------------------------------------------------------
// command_line_assembler_with_echo_test
// Self-checking bench for the command line assembler: drives typed bytes and
// fetch requests over the valid/stall input channel, predicts every echo and
// command word in a behavioral line editor, and checks the output channel
// word by word under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module command_line_assembler_with_echo_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cla_pkg::*;

    localparam int LINE_BYTES      = LINE_BYTES_DEF;
    localparam int WORDS_PER_PHASE = 100;
    localparam int HOLD_CYCLES     = 200;

    // how a scripted row is checked
    localparam logic [1:0] CHK_MODEL = 2'd0;
    localparam logic [1:0] CHK_ONE   = 2'd1;
    localparam logic [1:0] CHK_NONE  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } reply_t;

    typedef struct packed {
        logic       req;
        logic [7:0] b;
        logic [5:0] reps;
        logic [1:0] mode;
        logic [1:0] kind;
        logic [1:0] status;
    } script_row_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic       req_type  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;

    // line editor state mirrored by the bench
    logic [7:0] line_buf [LINE_BYTES];
    logic [7:0] cmd_buf  [LINE_BYTES];
    int         line_len = 0;
    int         cmd_len  = 0;
    logic [1:0] cmd_stat = ST_CLEAR;

    reply_t      reply_q[$];
    reply_t      step_replies[$];
    script_row_t script[$];
    reply_t      head_reply;

    int errors        = 0;
    int live_words    = 0;
    int send_idle_pct = 23;
    int recv_idle_pct = 77;
    bit hold_req      = 1'b0;

    command_line_assembler_with_echo #(
        .LINE_BYTES (LINE_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data      (data),
        .last      (last),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void add_reply(logic [1:0] k, logic [7:0] d);
        step_replies.push_back(reply_t'{kind: k, data: d, last: 1'b0, status: ST_CLEAR});
    endfunction

    // behavior of one accepted word; leaves its results in step_replies
    function automatic void line_editor_step(logic r, logic [7:0] b);
        step_replies.delete();
        if (r == REQ_FETCH)
        begin
            if (cmd_stat != ST_RECEIVED)
                add_reply(KIND_NONE, CH_ZERO);
            else
            begin
                cmd_stat = ST_CLEAR;
                if (cmd_len == 0)
                    add_reply(KIND_EMPTY, CH_ZERO);
                else
                    for (int i = 0; i < cmd_len; i++)
                        add_reply(KIND_CMD, cmd_buf[i]);
            end
        end
        else if (!b[7])
        begin
            if (b == CH_BS)
            begin
                // backspace rubs out only on a non-empty line
                if (line_len > 0)
                begin
                    line_len--;
                    add_reply(KIND_ECHO, CH_BS);
                    add_reply(KIND_ECHO, CH_SPACE);
                    add_reply(KIND_ECHO, CH_BS);
                end
            end
            else if (b == CH_CR || b == CH_LF || line_len >= LINE_BYTES - 2)
            begin
                // end of line or full line: latch, the byte itself is dropped
                for (int i = 0; i < line_len; i++)
                    cmd_buf[i] = line_buf[i];
                cmd_len  = line_len;
                line_len = 0;
                cmd_stat = ST_RECEIVED;
                add_reply(KIND_ECHO, CH_CR);
                add_reply(KIND_ECHO, CH_LF);
            end
            else
            begin
                line_buf[line_len] = b;
                line_len++;
                cmd_stat = ST_RECEIVING;
                add_reply(KIND_ECHO, b);
            end
        end
        foreach (step_replies[i])
        begin
            step_replies[i].status = cmd_stat;
            step_replies[i].last   = (i == step_replies.size() - 1);
        end
    endfunction

    // offer one word, entered and left at a falling edge
    task automatic send_word(input logic r, input logic [7:0] b,
                             input logic [1:0] mode = CHK_MODEL,
                             input logic [1:0] k = KIND_ECHO,
                             input logic [1:0] st = ST_CLEAR);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            req_type <= 1'($urandom_range(1, 0));
            rx_byte  <= 8'($urandom_range(255, 0));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        line_editor_step(r, b);
        if (step_replies.size() != 0)
            live_words++;
        case (mode)
            CHK_MODEL:
                foreach (step_replies[i])
                    reply_q.push_back(step_replies[i]);
            CHK_ONE:
                reply_q.push_back(reply_t'{kind: k,
                                           data: (k == KIND_ECHO) ? b : CH_ZERO,
                                           last: 1'b1, status: st});
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic void add_row(logic r, logic [7:0] b, int reps, logic [1:0] mode,
                                    logic [1:0] k = KIND_ECHO, logic [1:0] st = ST_CLEAR);
        script.push_back(script_row_t'{req: r, b: b, reps: 6'(reps), mode: mode,
                                       kind: k, status: st});
    endfunction

    // one typed line with edits and noise, usually followed by a fetch
    task automatic type_line();
        int         n_chars;
        int         pick;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if (pick < 80)
            n_chars = $urandom_range(8, 0);
        else if (pick < 95)
            n_chars = $urandom_range(20, 9);
        else
            n_chars = $urandom_range(34, 26);
        for (int i = 0; i < n_chars; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                ch = CH_BS;
            else if (pick < 15)
                ch = 8'($urandom_range(255, 128));
            else
                ch = 8'($urandom_range(127, 0));
            send_word(REQ_BYTE, ch);
        end
        if ($urandom_range(9) != 0)
            send_word(REQ_BYTE, $urandom_range(1, 0) ? CH_CR : CH_LF);
        if ($urandom_range(9) < 8)
            send_word(REQ_FETCH, 8'($urandom_range(255, 0)));
        if ($urandom_range(9) == 0)
            send_word(REQ_FETCH, 8'($urandom_range(255, 0)));
    endtask

    // stimulus
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed script
        add_row(REQ_FETCH, 8'h00, 1, CHK_ONE, KIND_NONE, ST_CLEAR);
        add_row(REQ_BYTE, CH_BS, 1, CHK_NONE);
        add_row(REQ_BYTE, 8'h80, 1, CHK_NONE);
        add_row(REQ_BYTE, 8'hFF, 1, CHK_NONE);
        add_row(REQ_BYTE, CH_ZERO, 1, CHK_ONE, KIND_ECHO, ST_RECEIVING);
        add_row(REQ_BYTE, 8'h7F, 1, CHK_ONE, KIND_ECHO, ST_RECEIVING);
        add_row(REQ_BYTE, CH_BS, 1, CHK_MODEL);
        add_row(REQ_FETCH, 8'hFF, 1, CHK_ONE, KIND_NONE, ST_RECEIVING);
        add_row(REQ_BYTE, CH_CR, 1, CHK_MODEL);
        add_row(REQ_FETCH, 8'h00, 1, CHK_MODEL);
        add_row(REQ_FETCH, 8'h00, 1, CHK_ONE, KIND_NONE, ST_CLEAR);
        add_row(REQ_BYTE, CH_LF, 1, CHK_MODEL);
        add_row(REQ_FETCH, 8'h00, 1, CHK_ONE, KIND_EMPTY, ST_CLEAR);
        add_row(REQ_BYTE, 8'h41, LINE_BYTES - 2, CHK_MODEL);
        add_row(REQ_BYTE, 8'hFF, 1, CHK_NONE);
        add_row(REQ_BYTE, 8'h5A, 1, CHK_MODEL);
        add_row(REQ_FETCH, 8'h00, 1, CHK_MODEL);
        add_row(REQ_BYTE, CH_SPACE, 1, CHK_MODEL);
        add_row(REQ_BYTE, CH_BS, 1, CHK_MODEL);
        add_row(REQ_BYTE, CH_BS, 1, CHK_NONE);
        add_row(REQ_BYTE, CH_CR, 1, CHK_MODEL);
        add_row(REQ_FETCH, 8'hA5, 1, CHK_ONE, KIND_EMPTY, ST_CLEAR);
        foreach (script[i])
            for (int j = 0; j < script[i].reps; j++)
                send_word(script[i].req, 8'(script[i].b + j), script[i].mode,
                          script[i].kind, script[i].status);

        // random lines in three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            int goal;
            case (ph)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 77;
                end
                1:
                begin
                    send_idle_pct = 77;
                    recv_idle_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req      = 1'b1;
                end
            endcase
            goal = live_words + WORDS_PER_PHASE;
            while (live_words < goal)
            begin
                if ($urandom_range(99) < 15)
                    send_word(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
                else
                    type_line();
            end
        end
        in_valid <= 1'b0;

        // drain the outstanding words, then watch for strays
        for (int w = 0; w < 100000 && reply_q.size() != 0; w++)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (reply_q.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, reply_q.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // output word checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (reply_q.size() == 0)
            begin
                $display("%0t: unexpected word, kind %0d data %0h last %0d status %0d",
                         $time, kind, data, last, status);
                errors++;
            end
            else
            begin
                head_reply = reply_q.pop_front();
                check_field("kind", head_reply.kind, kind);
                check_field("data", head_reply.data, data);
                check_field("last", head_reply.last, last);
                check_field("status", head_reply.status, status);
            end
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cla_pkg.sv
rtl/cla_datapath.sv
rtl/cla_ctrl.sv
rtl/command_line_assembler_with_echo.sv
rtl/cla_checker.sv
sim/command_line_assembler_with_echo_test.sv
